// ===== src/positional_list_store_assert.svh =====
// ----------------------------------------------------------------------------
// Assertion macros for the positional list store
// Shared property templates, sampled on the rising clock and off during reset.
// ----------------------------------------------------------------------------
`ifndef POSITIONAL_LIST_STORE_ASSERT_SVH
`define POSITIONAL_LIST_STORE_ASSERT_SVH

// Same-cycle implication.
`define PLST_ASSERT_IMP(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication.
`define PLST_ASSERT_NXT(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ===== src/plst_pkg.sv =====
// ----------------------------------------------------------------------------
// plst_pkg
// Sizes, request codes and cell control types for the positional list store.
// ----------------------------------------------------------------------------
`default_nettype none

package plst_pkg;

    localparam int DEPTH      = 64;
    localparam int ELEM_WIDTH = 32;

    localparam int TYPE_W  = 3;
    localparam int POS_W   = 8;
    localparam int VAL_W   = 32;
    localparam int OUT_W   = 7;
    localparam int CNT_W   = $clog2(DEPTH + 1);
    localparam int IDX_W   = $clog2(DEPTH);
    localparam int CMP_W   = ((POS_W > CNT_W) ? POS_W : CNT_W) + 1;

    typedef enum logic [TYPE_W-1:0] {
        REQ_INSERT   = 3'd0,
        REQ_LOCATE   = 3'd1,
        REQ_RETRIEVE = 3'd2,
        REQ_REMOVE   = 3'd3,
        REQ_CLEAR    = 3'd4
    } req_e;

    typedef enum logic [1:0] {
        CELL_HOLD  = 2'd0,
        CELL_LOAD  = 2'd1,
        CELL_LEFT  = 2'd2,
        CELL_RIGHT = 2'd3
    } cell_op_e;

    typedef struct packed {
        cell_op_e op;
    } cell_ctrl_t;

endpackage

`default_nettype wire

// ===== src/plst_req_if.sv =====
// ----------------------------------------------------------------------------
// plst_req_if
// Request channel: valid/ready handshake with one list request as payload.
// ----------------------------------------------------------------------------
`default_nettype none

interface plst_req_if;
    logic                       valid;
    logic                       ready;
    logic [plst_pkg::TYPE_W-1:0] req_type;
    logic [plst_pkg::POS_W-1:0]  position;
    logic [plst_pkg::VAL_W-1:0]  value;

    modport source (output valid, output req_type, output position, output value,
                    input ready);
    modport sink   (input valid, input req_type, input position, input value,
                    output ready);
endinterface

`default_nettype wire

// ===== src/plst_rsp_if.sv =====
// ----------------------------------------------------------------------------
// plst_rsp_if
// Result channel: valid/ready handshake with one request result as payload.
// ----------------------------------------------------------------------------
`default_nettype none

interface plst_rsp_if;
    logic                       valid;
    logic                       ready;
    logic                       ok;
    logic [plst_pkg::OUT_W-1:0] found_position;
    logic [plst_pkg::VAL_W-1:0] read_value;
    logic [plst_pkg::OUT_W-1:0] count;

    modport source (output valid, output ok, output found_position, output read_value,
                    output count, input ready);
    modport sink   (input valid, input ok, input found_position, input read_value,
                    input count, output ready);
endinterface

`default_nettype wire

// ===== src/plst_cell.sv =====
// ----------------------------------------------------------------------------
// plst_cell
// One list slot: holds an element, loads, shifts from a neighbor, compares.
// ----------------------------------------------------------------------------
`default_nettype none

module plst_cell (
    input  wire                              clk,
    input  wire plst_pkg::cell_ctrl_t        ctrl,
    input  wire [plst_pkg::ELEM_WIDTH-1:0]   load_value,
    input  wire [plst_pkg::ELEM_WIDTH-1:0]   left_data,
    input  wire [plst_pkg::ELEM_WIDTH-1:0]   right_data,
    input  wire [plst_pkg::ELEM_WIDTH-1:0]   key,
    output logic [plst_pkg::ELEM_WIDTH-1:0]  data,
    output logic                             hit
);

    logic [plst_pkg::ELEM_WIDTH-1:0] data_reg;
    logic [plst_pkg::ELEM_WIDTH-1:0] data_next;

    always_comb
    begin
        case (ctrl.op)
            plst_pkg::CELL_LOAD:  data_next = load_value;
            plst_pkg::CELL_LEFT:  data_next = left_data;
            plst_pkg::CELL_RIGHT: data_next = right_data;
            default:              data_next = data_reg;
        endcase
    end

    always_ff @(posedge clk)
    begin
        data_reg <= data_next;
    end

    assign data = data_reg;
    assign hit  = (data_reg == key);

endmodule

`default_nettype wire

// ===== src/positional_list_store.sv =====
// A result is registered and appears in the cycle after its request is accepted.
// Throughput: one request per cycle; every request finishes in the accept cycle
// because all cells shift, load or compare in parallel.
// A held result stalls new requests only while the result port is not ready.
// Reset clears the element count and the result valid; cell contents are kept
// and never read until written again.
// ----------------------------------------------------------------------------
// positional_list_store
// Ordered list held in a row of cells. Insert opens a gap by shifting the
// cells above the insert point up one slot; remove closes it by shifting the
// cells above the removed slot down. Locate compares every cell against the
// key at once and takes the lowest live hit. Retrieve selects one cell.
// ----------------------------------------------------------------------------
`default_nettype none

`include "positional_list_store_assert.svh"

module positional_list_store (
    input  wire         clk,
    input  wire         rst_n,
    plst_req_if.sink    req,
    plst_rsp_if.source  rsp
);

    localparam int DEPTH = plst_pkg::DEPTH;
    localparam int EW    = plst_pkg::ELEM_WIDTH;
    localparam int CNT_W = plst_pkg::CNT_W;
    localparam int CMP_W = plst_pkg::CMP_W;
    localparam int IDX_W = plst_pkg::IDX_W;
    localparam int OUT_W = plst_pkg::OUT_W;
    localparam int VAL_W = plst_pkg::VAL_W;

    // Control and result registers
    logic [CNT_W-1:0] len_reg;
    logic [CNT_W-1:0] len_next;
    logic             out_valid_reg;
    logic             out_valid_next;
    logic             ok_reg;
    logic             ok_next;
    logic [OUT_W-1:0] found_reg;
    logic [OUT_W-1:0] found_next;
    logic [VAL_W-1:0] rd_reg;
    logic [VAL_W-1:0] rd_next;
    logic [OUT_W-1:0] cnt_reg;
    logic [OUT_W-1:0] cnt_next;

    // Request decode
    logic             accept;
    logic [EW-1:0]    key;
    logic [CMP_W-1:0] pos_c;
    logic [CMP_W-1:0] len_c;
    logic [CMP_W-1:0] pos_m1;
    logic [CMP_W-1:0] at_c;
    logic             in_range;
    logic             ins_ok;
    logic             rem_ok;
    logic             is_clear;
    logic             is_locate;
    logic             is_retrieve;

    // Cell row
    logic [EW-1:0]        cell_data [DEPTH];
    logic                 cell_hit  [DEPTH];

    // Take a new request whenever the result slot is empty or being drained.
    assign req.ready = !out_valid_reg || rsp.ready;
    assign accept    = req.valid && req.ready;

    assign key    = EW'(req.value);
    assign pos_c  = CMP_W'(req.position);
    assign len_c  = CMP_W'(len_reg);
    assign pos_m1 = pos_c - CMP_W'(1);
    // Clamp the insert point to the end of the list: a far position appends.
    assign at_c   = (pos_m1 > len_c) ? len_c : pos_m1;

    assign in_range    = (pos_c != '0) && (pos_c <= len_c);
    assign ins_ok      = accept && (req.req_type == plst_pkg::REQ_INSERT)
                         && (pos_c != '0) && (len_reg != CNT_W'(DEPTH));
    assign rem_ok      = accept && (req.req_type == plst_pkg::REQ_REMOVE) && in_range;
    assign is_clear    = accept && (req.req_type == plst_pkg::REQ_CLEAR);
    assign is_locate   = (req.req_type == plst_pkg::REQ_LOCATE);
    assign is_retrieve = (req.req_type == plst_pkg::REQ_RETRIEVE);

    genvar gi;
    generate
        for (gi = 0; gi < DEPTH; gi++)
        begin : g_cell
            logic [CMP_W-1:0]     idx_c;
            logic [EW-1:0]        left_d;
            logic [EW-1:0]        right_d;
            plst_pkg::cell_ctrl_t ctrl_c;

            assign idx_c = CMP_W'(gi);

            if (gi == 0)
            begin : g_first
                assign left_d = '0;
            end
            else
            begin : g_mid_l
                assign left_d = cell_data[gi-1];
            end

            if (gi == DEPTH - 1)
            begin : g_last
                assign right_d = '0;
            end
            else
            begin : g_mid_r
                assign right_d = cell_data[gi+1];
            end

            // Pick this cell's move: load at the insert point, shift up above
            // it, shift down from the removed slot up to the slot below the old last element.
            always_comb
            begin
                ctrl_c.op = plst_pkg::CELL_HOLD;
                if (ins_ok)
                begin
                    if (idx_c == at_c)
                        ctrl_c.op = plst_pkg::CELL_LOAD;
                    else if ((idx_c > at_c) && (idx_c <= len_c))
                        ctrl_c.op = plst_pkg::CELL_LEFT;
                end
                else if (rem_ok)
                begin
                    if ((idx_c >= pos_m1) && ((idx_c + CMP_W'(1)) < len_c))
                        ctrl_c.op = plst_pkg::CELL_RIGHT;
                end
            end

            plst_cell u_cell (
                .clk        (clk),
                .ctrl       (ctrl_c),
                .load_value (key),
                .left_data  (left_d),
                .right_data (right_d),
                .key        (key),
                .data       (cell_data[gi]),
                .hit        (cell_hit[gi])
            );
        end
    endgenerate

    // Result and length update for the accepted request.
    always_comb
    begin
        logic [CNT_W-1:0] found_pos;
        logic             found_any;

        found_pos = '0;
        found_any = 1'b0;
        // Scan from the top so the lowest live hit wins.
        for (int i = DEPTH - 1; i >= 0; i--)
        begin
            if (cell_hit[i] && (CNT_W'(i) < len_reg))
            begin
                found_pos = CNT_W'(i + 1);
                found_any = 1'b1;
            end
        end

        len_next = len_reg;
        if (ins_ok)
            len_next = len_reg + CNT_W'(1);
        else if (rem_ok)
            len_next = len_reg - CNT_W'(1);
        else if (is_clear)
            len_next = '0;

        out_valid_next = out_valid_reg;
        ok_next        = ok_reg;
        found_next     = found_reg;
        rd_next        = rd_reg;
        cnt_next       = cnt_reg;

        if (accept)
        begin
            out_valid_next = 1'b1;
            ok_next        = ins_ok || rem_ok || is_clear
                             || (is_locate && found_any)
                             || (is_retrieve && in_range);
            found_next     = is_locate ? OUT_W'(found_pos) : '0;
            rd_next        = (is_retrieve && in_range)
                             ? VAL_W'(cell_data[pos_m1[IDX_W-1:0]]) : '0;
            cnt_next       = OUT_W'(len_next);
        end
        else if (rsp.ready)
        begin
            // Drop the result once it has been taken.
            out_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            len_reg       <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            len_reg       <= len_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        ok_reg    <= ok_next;
        found_reg <= found_next;
        rd_reg    <= rd_next;
        cnt_reg   <= cnt_next;
    end

    assign rsp.valid          = out_valid_reg;
    assign rsp.ok             = ok_reg;
    assign rsp.found_position = found_reg;
    assign rsp.read_value     = rd_reg;
    assign rsp.count          = cnt_reg;

    `PLST_ASSERT_IMP(a_len_bound, clk, rst_n, 1'b1, len_reg <= CNT_W'(DEPTH), "length above depth")
    `PLST_ASSERT_NXT(a_clear_empties, clk, rst_n, is_clear, len_reg == '0, "clear left elements")
    `PLST_ASSERT_NXT(a_insert_grows, clk, rst_n, ins_ok, len_reg == $past(len_reg) + 1'b1, "insert did not grow list")
    `PLST_ASSERT_IMP(a_found_ok, clk, rst_n, out_valid_reg && (found_reg != '0), ok_reg, "locate hit without ok")

endmodule

`default_nettype wire

// ===== test/tb_top.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_top
// Self-checking bench for the positional list store. A behavioral list model
// predicts every result at request acceptance; a checker compares each
// accepted result with the oldest prediction, field by field.
// ----------------------------------------------------------------------------

module tb_top;

    import plst_pkg::*;

    localparam int CLK_PERIOD       = 10;
    localparam int RESET_CYCLES     = 11;
    localparam int CYCLE_LIMIT      = 300000;
    localparam int SETTLE_CYCLES    = 20;
    localparam int RANDOM_PER_PHASE = 215;
    localparam int BURST_LEN        = 40;
    localparam int HOLD_OFF_CYCLES  = 150;
    localparam int PRESSURE_ITEMS   = 24;
    localparam int NUM_CODES        = 1 << TYPE_W;

    // Codes past the last defined request; the block must answer them
    // with a do-nothing result.
    localparam logic [TYPE_W-1:0] REQ_UNUSED_FIRST = 3'd5;
    localparam logic [TYPE_W-1:0] REQ_UNUSED_LAST  = {TYPE_W{1'b1}};
    localparam logic [POS_W-1:0]  POS_MAX          = {POS_W{1'b1}};
    localparam logic [VAL_W-1:0]  VAL_MAX          = {VAL_W{1'b1}};

    typedef struct packed {
        logic             ok;
        logic [OUT_W-1:0] found_position;
        logic [VAL_W-1:0] read_value;
        logic [OUT_W-1:0] count;
    } list_result_t;

    logic clk;
    logic rst_n;

    plst_req_if req();
    plst_rsp_if rsp();

    positional_list_store dut (
        .clk   (clk),
        .rst_n (rst_n),
        .req   (req),
        .rsp   (rsp)
    );

    // ------------------------------------------------------------------------
    // Shadow list and bookkeeping
    // ------------------------------------------------------------------------
    logic [ELEM_WIDTH-1:0] list_cells [DEPTH];
    int unsigned           list_len = 0;

    // Predicted results, oldest first.
    list_result_t pending_results [$];

    int unsigned mismatch_count = 0;
    int unsigned request_count  = 0;
    int unsigned result_count   = 0;
    int unsigned full_hits      = 0;
    int unsigned kind_count [NUM_CODES];
    int unsigned cycle_count    = 0;

    // Idling knobs, in percent of cycles.
    int send_idle_pct  = 0;
    int recv_stall_pct = 0;
    // Remaining cycles of a forced receiver hold-off.
    int hold_left      = 0;

    initial
    begin
        clk = 1'b0;
        forever #(CLK_PERIOD / 2) clk = ~clk;
    end

    // ------------------------------------------------------------------------
    // List model: apply one request to the shadow list and return the result
    // the block owes for it.
    // ------------------------------------------------------------------------
    function automatic list_result_t apply_request(
        input logic [TYPE_W-1:0] kind,
        input logic [POS_W-1:0]  pos,
        input logic [VAL_W-1:0]  val
    );
        list_result_t          r;
        int unsigned           slot;
        int unsigned           k;
        logic [ELEM_WIDTH-1:0] key;
        r   = '0;
        key = val[ELEM_WIDTH-1:0];
        case (kind)
            REQ_INSERT:
            begin
                // Position zero and a full list are refused; a position past
                // the end appends.
                if (pos != '0 && list_len < DEPTH)
                begin
                    slot = int'(pos) - 1;
                    if (slot > list_len)
                        slot = list_len;
                    for (k = list_len; k > slot; k--)
                        list_cells[k] = list_cells[k - 1];
                    list_cells[slot] = key;
                    list_len++;
                    r.ok = 1'b1;
                end
            end
            REQ_LOCATE:
            begin
                // First hit wins.
                for (k = 0; k < list_len && !r.ok; k++)
                begin
                    if (list_cells[k] == key)
                    begin
                        r.found_position = OUT_W'(k + 1);
                        r.ok             = 1'b1;
                    end
                end
            end
            REQ_RETRIEVE:
            begin
                if (pos != '0 && pos <= list_len)
                begin
                    r.read_value = VAL_W'(list_cells[pos - 1]);
                    r.ok         = 1'b1;
                end
            end
            REQ_REMOVE:
            begin
                if (pos != '0 && pos <= list_len)
                begin
                    for (k = int'(pos) - 1; k + 1 < list_len; k++)
                        list_cells[k] = list_cells[k + 1];
                    list_len--;
                    r.ok = 1'b1;
                end
            end
            REQ_CLEAR:
            begin
                list_len = 0;
                r.ok     = 1'b1;
            end
            default:
            begin
                // Unused codes leave the list alone and report failure.
            end
        endcase
        r.count = OUT_W'(list_len);
        return r;
    endfunction

    task automatic report_mismatch(
        input string            what,
        input logic [VAL_W-1:0] want,
        input logic [VAL_W-1:0] got
    );
        mismatch_count++;
        $display("MISMATCH cycle %0d result %0d: %s expected 0x%0h got 0x%0h",
                 cycle_count, result_count, what, want, got);
    endtask

    task automatic check_result();
        list_result_t want;
        result_count++;
        if (pending_results.size() == 0)
        begin
            report_mismatch("unexpected result, count", '0, VAL_W'(rsp.count));
            return;
        end
        want = pending_results.pop_front();
        if (rsp.ok !== want.ok)
            report_mismatch("ok", VAL_W'(want.ok), VAL_W'(rsp.ok));
        if (rsp.found_position !== want.found_position)
            report_mismatch("found_position", VAL_W'(want.found_position),
                            VAL_W'(rsp.found_position));
        if (rsp.read_value !== want.read_value)
            report_mismatch("read_value", want.read_value, rsp.read_value);
        if (rsp.count !== want.count)
            report_mismatch("count", VAL_W'(want.count), VAL_W'(rsp.count));
    endtask

    // ------------------------------------------------------------------------
    // Monitor: sample both channels on the rising edge. Check the result
    // first so that a request accepted in the same cycle queues behind it.
    // ------------------------------------------------------------------------
    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if (rsp.valid && rsp.ready)
                check_result();
            if (req.valid && req.ready)
            begin
                pending_results.push_back(
                    apply_request(req.req_type, req.position, req.value));
                request_count++;
                kind_count[req.req_type]++;
                if (list_len == DEPTH)
                    full_hits++;
            end
        end
    end

    // Watchdog on total run length.
    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= CYCLE_LIMIT)
        begin
            $display("Timed out after %0d cycles with %0d results outstanding",
                     cycle_count, pending_results.size());
            $display("Verification failed");
            $finish;
        end
    end

    // ------------------------------------------------------------------------
    // Result sink: drive ready on the falling edge. A forced hold-off counts
    // down here and overrides the random stalls.
    // ------------------------------------------------------------------------
    always @(negedge clk)
    begin
        if (hold_left > 0)
        begin
            hold_left   = hold_left - 1;
            rsp.ready  <= 1'b0;
        end
        else
        begin
            rsp.ready <= ($urandom_range(99) >= recv_stall_pct);
        end
    end

    // ------------------------------------------------------------------------
    // Request source
    // ------------------------------------------------------------------------

    // Offer one request and hold it until accepted. Valid stays high on
    // return so back-to-back requests keep it asserted unless idling is set.
    task automatic send_request(
        input logic [TYPE_W-1:0] kind,
        input logic [POS_W-1:0]  pos,
        input logic [VAL_W-1:0]  val
    );
        @(negedge clk);
        while ($urandom_range(99) < send_idle_pct)
        begin
            // Idle with garbage on the payload.
            req.valid    <= 1'b0;
            req.req_type <= TYPE_W'($urandom);
            req.position <= POS_W'($urandom);
            req.value    <= $urandom;
            @(negedge clk);
        end
        req.valid    <= 1'b1;
        req.req_type <= kind;
        req.position <= pos;
        req.value    <= val;
        do
            @(posedge clk);
        while (!req.ready);
    endtask

    task automatic stop_sending();
        @(negedge clk);
        req.valid <= 1'b0;
    endtask

    // Pause until every predicted result has come back.
    task automatic drain_results();
        while (pending_results.size() != 0)
            @(posedge clk);
    endtask

    // Build one random request. Positions mostly land in or just past the
    // live range, values often repeat or match a stored element so that
    // locate hits and duplicates occur.
    task automatic random_request(input int insert_pct);
        logic [TYPE_W-1:0] kind;
        logic [POS_W-1:0]  pos;
        logic [VAL_W-1:0]  val;
        int unsigned       roll;
        if ($urandom_range(99) < insert_pct)
            kind = REQ_INSERT;
        else
        begin
            roll = $urandom_range(99);
            if (roll < 32)
                kind = REQ_LOCATE;
            else if (roll < 62)
                kind = REQ_RETRIEVE;
            else if (roll < 96)
                kind = REQ_REMOVE;
            else if (roll < 98)
                kind = REQ_CLEAR;
            else
                kind = TYPE_W'($urandom_range(REQ_UNUSED_FIRST, REQ_UNUSED_LAST));
        end

        roll = $urandom_range(9);
        if (roll == 0)
            pos = POS_W'($urandom_range(POS_MAX));
        else if (roll == 1)
            pos = '0;
        else if (roll == 2)
            pos = POS_W'(list_len + $urandom_range(1));
        else
            pos = POS_W'($urandom_range(1, (list_len == 0) ? 1 : list_len));

        roll = $urandom_range(9);
        if (roll < 4)
            val = VAL_W'($urandom_range(15));
        else if (roll == 4)
            val = $urandom_range(1) ? VAL_MAX : '0;
        else if (roll < 7 && list_len != 0)
            val = VAL_W'(list_cells[$urandom_range(list_len - 1)]);
        else
            val = $urandom;

        send_request(kind, pos, val);
    endtask

    // ------------------------------------------------------------------------
    // Tests
    // ------------------------------------------------------------------------

    // Edge cases on a small list: empty-list failures, refused insert at
    // position zero, append past the end, duplicates, out-of-range access,
    // unused codes and clear.
    task automatic test_directed();
        send_idle_pct  = 0;
        recv_stall_pct = 0;
        send_request(REQ_LOCATE,   8'd0,    32'd0);
        send_request(REQ_RETRIEVE, 8'd1,    32'd0);
        send_request(REQ_REMOVE,   8'd0,    32'd0);
        send_request(REQ_INSERT,   8'd0,    32'd7);
        send_request(REQ_INSERT,   8'd1,    32'd0);
        send_request(REQ_INSERT,   POS_MAX, VAL_MAX);
        send_request(REQ_INSERT,   8'd1,    32'd5);
        send_request(REQ_INSERT,   8'd2,    32'd5);
        send_request(REQ_LOCATE,   8'd0,    32'd5);
        send_request(REQ_LOCATE,   POS_MAX, VAL_MAX);
        send_request(REQ_LOCATE,   8'd1,    32'd9);
        send_request(REQ_RETRIEVE, 8'd0,    32'd0);
        send_request(REQ_RETRIEVE, 8'd4,    32'd0);
        send_request(REQ_RETRIEVE, 8'd5,    32'd0);
        send_request(REQ_REMOVE,   POS_MAX, 32'd0);
        send_request(REQ_REMOVE,   8'd2,    32'd0);
        send_request(REQ_RETRIEVE, 8'd2,    32'd0);
        send_request(REQ_UNUSED_FIRST, 8'd1, 32'd5);
        send_request(TYPE_W'(6),       8'd2, 32'd0);
        send_request(REQ_UNUSED_LAST,  POS_MAX, VAL_MAX);
        send_request(REQ_CLEAR,    8'd0,    32'd0);
        send_request(REQ_LOCATE,   8'd0,    32'd0);
        send_request(REQ_CLEAR,    8'd0,    32'd0);
    endtask

    // Fill the list to capacity, bounce off the full-list rule, then work
    // the last slot.
    task automatic test_capacity();
        logic [VAL_W-1:0] tail_val;
        send_idle_pct  = 20;
        recv_stall_pct = 20;
        tail_val = '0;
        for (int i = 0; i < DEPTH; i++)
        begin
            tail_val = $urandom;
            send_request(REQ_INSERT, POS_W'($urandom_range(1, POS_MAX)), tail_val);
        end
        send_request(REQ_INSERT,   8'd1,          32'd1);
        send_request(REQ_INSERT,   8'd0,          32'd1);
        send_request(REQ_RETRIEVE, POS_W'(DEPTH), 32'd0);
        send_request(REQ_RETRIEVE, POS_W'(DEPTH + 1), 32'd0);
        send_request(REQ_LOCATE,   8'd0,          tail_val);
        send_request(REQ_REMOVE,   POS_W'(DEPTH), 32'd0);
        send_request(REQ_INSERT,   POS_MAX,       VAL_MAX);
        send_request(REQ_LOCATE,   8'd0,          VAL_MAX);
        send_request(REQ_INSERT,   POS_MAX,       32'd3);
        send_request(REQ_CLEAR,    8'd0,          32'd0);
    endtask

    // Random traffic under one idling setting; the insert share swings per
    // burst so the list both fills up and drains.
    task automatic test_random(input int idle_pct, input int stall_pct);
        int insert_pct;
        send_idle_pct  = idle_pct;
        recv_stall_pct = stall_pct;
        insert_pct     = 50;
        for (int i = 0; i < RANDOM_PER_PHASE; i++)
        begin
            if (i % BURST_LEN == 0)
            begin
                case ($urandom_range(2))
                    0:       insert_pct = 25;
                    1:       insert_pct = 50;
                    default: insert_pct = 75;
                endcase
            end
            random_request(insert_pct);
        end
    endtask

    // Hold the result port off while requests keep coming so the block fills
    // and stalls its input, then wait out every result before moving on.
    task automatic test_backpressure();
        send_idle_pct  = 0;
        recv_stall_pct = 0;
        hold_left      = HOLD_OFF_CYCLES;
        for (int i = 0; i < PRESSURE_ITEMS; i++)
            random_request(60);
        stop_sending();
        drain_results();
    endtask

    // ------------------------------------------------------------------------
    // Main sequence
    // ------------------------------------------------------------------------
    initial
    begin
        int unsigned unused_hits;
        rst_n        = 1'b0;
        req.valid    = 1'b0;
        req.req_type = '0;
        req.position = '0;
        req.value    = '0;
        rsp.ready    = 1'b0;
        foreach (kind_count[i])
            kind_count[i] = 0;
        repeat (RESET_CYCLES) @(negedge clk);
        rst_n = 1'b1;

        test_directed();
        test_capacity();
        test_random(0, 0);
        test_random(82, 0);
        test_backpressure();
        test_random(0, 82);
        test_random(20, 20);

        stop_sending();
        drain_results();
        repeat (SETTLE_CYCLES) @(posedge clk);
        if (pending_results.size() != 0)
            report_mismatch("results left over", '0, VAL_W'(pending_results.size()));

        unused_hits = 0;
        for (int c = REQ_UNUSED_FIRST; c <= REQ_UNUSED_LAST; c++)
            unused_hits += kind_count[c];
        $display("Ran %0d requests: %0d insert, %0d locate, %0d retrieve, %0d remove, %0d clear, %0d unused code; %0d results checked",
                 request_count, kind_count[REQ_INSERT], kind_count[REQ_LOCATE],
                 kind_count[REQ_RETRIEVE], kind_count[REQ_REMOVE],
                 kind_count[REQ_CLEAR], unused_hits, result_count);
        $display("List at full capacity after %0d requests; %0d mismatches",
                 full_hits, mismatch_count);
        if (mismatch_count == 0)
            $display("Verification passed");
        else
            $display("Verification failed");
        $finish;
    end

endmodule
